/* hdl/shf_pkg.sv */
// ----------------------------------------------------------------------------
// shf_pkg
// Shared types, constants and helpers of the substring hit finder.
// ----------------------------------------------------------------------------
package shf_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int PAT_IDX_BITS  = $clog2(MAX_PATTERN);
	localparam int LEN_BITS      = 5;
	localparam int OFFSET_BITS   = 32;
	localparam int POS_BITS      = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [POS_BITS-1:0] POS_SAT      = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] POS_ONE      = POS_BITS'(1);
	localparam logic [7:0]          NEWLINE_BYTE = 8'h0A;

	// register indexes on the configuration port
	localparam logic [2:0] REG_PAT_LOW   = 3'd0;
	localparam logic [2:0] REG_PAT_HIGH  = 3'd1;
	localparam logic [2:0] REG_PAT_LEN   = 3'd2;
	localparam logic [2:0] REG_CASE_SENS = 3'd3;
	localparam logic [2:0] REG_HIT_LIMIT = 3'd4;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        first_of_file;
		logic [15:0] file_number;
	} text_word_t;

	typedef struct packed {
		logic [15:0]          hit_file;
		logic [POS_BITS-1:0]  hit_line;
		logic [POS_BITS-1:0]  hit_column;
		logic [31:0]          hit_offset;
	} hit_word_t;

	// byte carrying its position, moved from front to back
	typedef struct packed {
		logic [7:0]             text_byte;
		logic                   first_of_file;
		logic [15:0]            file_number;
		logic [POS_BITS-1:0]    line;
		logic [POS_BITS-1:0]    column;
		logic [OFFSET_BITS-1:0] offset;
	} pos_word_t;

	typedef struct packed {
		logic [63:0]         pattern_bytes_low;
		logic [63:0]         pattern_bytes_high;
		logic [LEN_BITS-1:0] pattern_length;
		logic                match_exact;
		logic [15:0]         hit_limit;
	} cfg_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
		logic [7:0] r;
		r = b;
		if (!cs && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

/* hdl/shf_cfg.sv */
// ----------------------------------------------------------------------------
// shf_cfg
// APB register file holding pattern, length, case mode and hit limit.
// ----------------------------------------------------------------------------
module shf_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output shf_pkg::cfg_t cfg
);
	import shf_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PAT_LOW:   cfg_q.pattern_bytes_low  <= pwdata;
				REG_PAT_HIGH:  cfg_q.pattern_bytes_high <= pwdata;
				REG_PAT_LEN:   cfg_q.pattern_length     <= pwdata[LEN_BITS-1:0];
				REG_CASE_SENS: cfg_q.match_exact        <= pwdata[0];
				REG_HIT_LIMIT: cfg_q.hit_limit          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAT_LOW:   prdata = cfg_q.pattern_bytes_low;
			REG_PAT_HIGH:  prdata = cfg_q.pattern_bytes_high;
			REG_PAT_LEN:   prdata = 64'(cfg_q.pattern_length);
			REG_CASE_SENS: prdata = 64'(cfg_q.match_exact);
			REG_HIT_LIMIT: prdata = 64'(cfg_q.hit_limit);
			default:       prdata = '0;
		endcase
	end

endmodule

/* hdl/shf_front.sv */
// ----------------------------------------------------------------------------
// shf_front
// Mark each accepted byte with its line, column and offset in its file.
// ----------------------------------------------------------------------------
module shf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  shf_pkg::text_word_t word,
	output shf_pkg::pos_word_t  pos_word
);
	import shf_pkg::*;

	logic [POS_BITS-1:0]    line_q, column_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [POS_BITS-1:0]    line_cur, column_cur;
	logic [OFFSET_BITS-1:0] offset_cur;

	// restart counts on the first byte of a file
	always_comb begin
		line_cur   = word.first_of_file ? POS_ONE : line_q;
		column_cur = word.first_of_file ? POS_ONE : column_q;
		offset_cur = word.first_of_file ? '0 : offset_q;
		pos_word.text_byte     = word.text_byte;
		pos_word.first_of_file = word.first_of_file;
		pos_word.file_number   = word.file_number;
		pos_word.line          = line_cur;
		pos_word.column        = column_cur;
		pos_word.offset        = offset_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= POS_ONE;
			column_q <= POS_ONE;
			offset_q <= '0;
		end else if (accept) begin
			offset_q <= offset_cur + OFFSET_BITS'(1);
			if (word.text_byte == NEWLINE_BYTE) begin
				line_q   <= (line_cur != POS_SAT) ? line_cur + POS_ONE : line_cur;
				column_q <= POS_ONE;
			end else begin
				line_q   <= line_cur;
				column_q <= (column_cur != POS_SAT) ? column_cur + POS_ONE : column_cur;
			end
		end
	end

endmodule

/* hdl/shf_queue.sv */
// ----------------------------------------------------------------------------
// shf_queue
// Short queue of position-marked bytes between front and back.
// ----------------------------------------------------------------------------
module shf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  shf_pkg::pos_word_t wr_data,
	output logic               full,
	input  logic               rd,
	output logic               valid,
	output shf_pkg::pos_word_t rd_data
);
	import shf_pkg::*;

	pos_word_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full    = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !rd) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> count_q == $past(count_q) + 1'b1) else $error("count slip");
`endif

endmodule

/* hdl/shf_back.sv */
// ----------------------------------------------------------------------------
// shf_back
// Window, compare, suppression and hit limit; holds results in a 2-word queue.
// ----------------------------------------------------------------------------
module shf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  shf_pkg::cfg_t       cfg,
	input  logic                mid_valid,
	input  shf_pkg::pos_word_t  mid,
	output logic                mid_take,
	output logic                empty,
	input  logic                pop,
	output shf_pkg::hit_word_t  hit_word
);
	import shf_pkg::*;

	logic [7:0]             win_byte_q  [MAX_PATTERN];
	logic [POS_BITS-1:0]    win_line_q  [MAX_PATTERN];
	logic [POS_BITS-1:0]    win_col_q   [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] win_off_q   [MAX_PATTERN];
	logic [7:0]             win_byte_n  [MAX_PATTERN];
	logic [POS_BITS-1:0]    win_line_n  [MAX_PATTERN];
	logic [POS_BITS-1:0]    win_col_n   [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] win_off_n   [MAX_PATTERN];

	logic [LEN_BITS-1:0]     fill_q, sup_q, fill_eff, sup_eff, fill_new, len;
	logic [15:0]             hits_q;
	logic [127:0]            pat_all;
	logic [PAT_IDX_BITS-1:0] pidx, first_idx;
	logic                    len_ok, match, hit, take_hit;

	hit_word_t out_q [2];
	hit_word_t hit_n;
	logic      owr_q, ord_q;
	logic [1:0] ocount_q;
	logic      out_room, opop;

	assign opop     = pop && !empty;
	assign out_room = (ocount_q != 2'd2) || opop;
	assign mid_take = mid_valid && out_room;
	assign empty    = (ocount_q == 2'd0);
	assign hit_word = out_q[ord_q];

	always_comb begin
		len      = cfg.pattern_length;
		pat_all  = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};
		fill_eff = mid.first_of_file ? '0 : fill_q;
		sup_eff  = mid.first_of_file ? '0 : sup_q;
		fill_new = (fill_eff < LEN_BITS'(MAX_PATTERN)) ? fill_eff + 1'b1 : fill_eff;
		len_ok   = (len != '0) && (len <= LEN_BITS'(MAX_PATTERN));

		win_byte_n[0] = mid.text_byte;
		win_line_n[0] = mid.line;
		win_col_n[0]  = mid.column;
		win_off_n[0]  = mid.offset;
		for (int s = 1; s < MAX_PATTERN; s++) begin
			win_byte_n[s] = win_byte_q[s-1];
			win_line_n[s] = win_line_q[s-1];
			win_col_n[s]  = win_col_q[s-1];
			win_off_n[s]  = win_off_q[s-1];
		end

		// slot s holds pattern byte len-1-s
		match = 1'b1;
		pidx  = '0;
		for (int s = 0; s < MAX_PATTERN; s++) begin
			if (LEN_BITS'(s) < len) begin
				pidx = PAT_IDX_BITS'(len - LEN_BITS'(s) - LEN_BITS'(1));
				if (fold_byte(win_byte_n[s], cfg.match_exact) !=
				    fold_byte(pat_all[pidx*8 +: 8], cfg.match_exact)) begin
					match = 1'b0;
				end
			end
		end

		hit = (sup_eff == '0) && len_ok && (fill_new >= len) &&
		      (hits_q < cfg.hit_limit) && match;
		take_hit = mid_take && hit;

		first_idx        = PAT_IDX_BITS'(len - LEN_BITS'(1));
		hit_n.hit_file   = mid.file_number;
		hit_n.hit_line   = win_line_n[first_idx];
		hit_n.hit_column = win_col_n[first_idx];
		hit_n.hit_offset = 32'(win_off_n[first_idx]);
	end

	always_ff @(posedge clk) begin
		if (mid_take) begin
			for (int s = 0; s < MAX_PATTERN; s++) begin
				win_byte_q[s] <= win_byte_n[s];
				win_line_q[s] <= win_line_n[s];
				win_col_q[s]  <= win_col_n[s];
				win_off_q[s]  <= win_off_n[s];
			end
		end
		if (take_hit) begin
			out_q[owr_q] <= hit_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			sup_q    <= '0;
			hits_q   <= '0;
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			if (mid_take) begin
				fill_q <= fill_new;
				if (sup_eff != '0) begin
					sup_q <= sup_eff - 1'b1;
				end else if (hit) begin
					sup_q <= len - 1'b1;
				end else begin
					sup_q <= '0;
				end
			end
			if (take_hit) begin
				hits_q <= hits_q + 1'b1;
				owr_q  <= ~owr_q;
			end
			if (opop) ord_q <= ~ord_q;
			case ({take_hit, opop})
				2'b10:   ocount_q <= ocount_q + 1'b1;
				2'b01:   ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_BITS'(MAX_PATTERN)) else $error("fill count out of range");
	a_sup_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sup_q < LEN_BITS'(MAX_PATTERN)) else $error("suppression out of range");
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocount_q <= 2'd2) else $error("result queue overflow");
	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		take_hit |=> hits_q == $past(hits_q) + 1'b1) else $error("hit count slip");
`endif

endmodule

/* hdl/substring_hit_finder_core.sv */
// ----------------------------------------------------------------------------
// substring_hit_finder_core
// Streaming search for a configured pattern of up to 16 bytes in file text.
// ----------------------------------------------------------------------------
//  channel     | handshake          | payload
//  ------------+--------------------+-------------------------------------
//  text in     | push / full        | text_word (byte, first mark, file)
//  hits out    | pop / empty        | hit_word (file, line, column, offset)
//  config      | APB psel..pready   | 64-bit registers at 8*index
//
//  One byte is taken per cycle while full is low; throughput is set by
//  the back end, which compares the whole window against the pattern
//  combinationally. A byte reaches the back through the queue, later while
//  the back stalls; a hit enters the result queue when the back takes its last byte.
//  Reset clears counters, limits and queues; window payload is not cleared.
//  A full result queue stalls the back; the 4-word tag queue then fills and
//  raises full.
// ----------------------------------------------------------------------------
module substring_hit_finder_core (
	input  logic                clk,
	input  logic                arst_n,
	// text side
	input  logic                push,
	output logic                full,
	input  shf_pkg::text_word_t text_word,
	// hit side
	output logic                empty,
	input  logic                pop,
	output shf_pkg::hit_word_t  hit_word,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	import shf_pkg::*;

	cfg_t      cfg;
	pos_word_t pos_word, mid;
	logic      accept, mid_valid, mid_take;

	// APB never waits
	assign pready = 1'b1;
	assign accept = push && !full;

	shf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// front: mark each word with its position in the file
	shf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (text_word),
		.pos_word (pos_word)
	);

	// decouple front from back so each side stalls on its own
	shf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_data (pos_word),
		.full    (full),
		.rd      (mid_take),
		.valid   (mid_valid),
		.rd_data (mid)
	);

	// back: shift the window, compare, suppress and count hits
	shf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_valid (mid_valid),
		.mid       (mid),
		.mid_take  (mid_take),
		.empty     (empty),
		.pop       (pop),
		.hit_word  (hit_word)
	);

endmodule
